// ----- hdl/sar_pkg.sv -----
// Shared types and codes for the sorted allocation registry.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package sar_pkg;

    localparam int KEY_W     = 64;
    localparam int TYPE_W    = 4;
    localparam int COUNT_W   = 31;
    localparam int EBYTES_W  = 16;
    localparam int SOURCE_W  = 16;
    localparam int LINE_W    = 20;
    localparam int TOTAL_W   = 47;
    localparam int POS_W     = 6;
    localparam int OCC_W     = 7;
    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 152;

    // Action codes carried on s_tuser; any other code acts as a lookup
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;

    // Status codes carried on m_tuser
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef logic [KEY_W-1:0] key_t;

    // One allocation record, type tag in the lowest bits
    typedef struct packed {
        logic [LINE_W-1:0]   line;
        logic [SOURCE_W-1:0] source;
        logic [EBYTES_W-1:0] elem_bytes;
        logic [COUNT_W-1:0]  count;
        logic [TYPE_W-1:0]   type_tag;
    } rec_t;

    // Input beat layout on s_tdata
    typedef struct packed {
        logic [0:0] pad;
        rec_t       rec;
        key_t       key;
    } in_beat_t;

    // Output beat layout on m_tdata
    typedef struct packed {
        logic [4:0]         pad;
        logic [OCC_W-1:0]   occupancy;
        logic [TOTAL_W-1:0] byte_total;
        rec_t               rec;
        logic [POS_W-1:0]   position;
    } out_beat_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
        logic del_en;
        key_t key;
        rec_t rec;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/sorted_allocation_registry.sv -----
// Sorted allocation registry: top level with sequencer, cell chain and result register.
// Depends on sar_pkg and sar_cell.
//
// Keeps up to CAPACITY allocation records sorted by 64-bit address in a chain of
// cells, one record per cell. Each input beat is an insert, delete or lookup
// (s_tuser); each produces exactly one output beat with a status on m_tuser.
// An action passes through the states idle, where it is accepted, compare, in which
// every cell compares its key with the request at once, apply, in which the cells
// shift to open or close a slot while the matching record is read out, and emit,
// which registers the element-size times count product and waits while an untaken
// result still holds m_tdata. No new beat is accepted until the action is emitted;
// the next beat may be taken while a finished result still waits on m_tdata.
// Only records in occupied cells are ever read, so no clearing is needed after reset.
`default_nettype none

module sorted_allocation_registry #(
    parameter int CAPACITY = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // key_address[63:0], type_tag[67:64], element_count[98:68],
    // element_bytes[114:99], source_tag[130:115], source_line[150:131]
    input  wire logic [sar_pkg::IN_DATA_W-1:0]   s_tdata,
    // action[1:0]
    input  wire logic [sar_pkg::ACTION_W-1:0]    s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // position[5:0], rec_type[9:6], rec_count[40:10], rec_elem_bytes[56:41],
    // rec_source[72:57], rec_line[92:73], byte_total[139:93], occupancy[146:140]
    output logic [sar_pkg::OUT_DATA_W-1:0]       m_tdata,
    // status[1:0]
    output logic [sar_pkg::STATUS_W-1:0]         m_tuser
);
    import sar_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t                state_reg;
    logic [ACTION_W-1:0]   act_reg;
    key_t                  key_reg;
    rec_t                  new_rec_reg;
    logic [PW-1:0]         fill_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [POS_W-1:0]      res_pos_reg;
    rec_t                  res_rec_reg;
    logic                  m_tvalid_reg;
    out_beat_t             m_beat_reg;
    logic [STATUS_W-1:0]   m_status_reg;

    logic [STATUS_W-1:0]   status_next;
    logic [POS_W-1:0]      pos_next;
    rec_t                  rec_next;
    logic [PW-1:0]         fill_next;

    in_beat_t              in_beat;
    cell_ctl_t             ctl;
    logic                  hit;
    logic                  full;
    logic                  is_ins;
    logic                  is_del;
    logic [PW-1:0]         slot;
    rec_t                  found_rec;
    logic [TOTAL_W-1:0]    product;

    logic [CAPACITY-1:0]   lt_vec;
    logic [CAPACITY-1:0]   eq_vec;
    logic [CAPACITY-1:0]   valid_vec;
    key_t                  key_arr [CAPACITY];
    rec_t                  rec_arr [CAPACITY];

    assign in_beat = in_beat_t'(s_tdata);

    // Decode the held action
    always_comb
    begin
        is_ins = 1'b0;
        is_del = 1'b0;
        case (act_reg)
            ACT_INSERT: is_ins = 1'b1;
            ACT_DELETE: is_del = 1'b1;
            default:    is_ins = 1'b0;
        endcase
    end

    assign hit  = |eq_vec;
    assign full = (fill_reg == PW'(CAPACITY));

    // Broadcast control to the chain
    always_comb
    begin
        ctl.cmp_en = (state_reg == ST_CMP);
        ctl.ins_en = (state_reg == ST_APPLY) && is_ins && !full && !hit;
        ctl.del_en = (state_reg == ST_APPLY) && is_del && hit;
        ctl.key    = key_reg;
        ctl.rec    = new_rec_reg;
    end

    // Build the chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic l_lt;
        logic l_valid;
        key_t l_key;
        rec_t l_rec;
        logic r_valid;
        key_t r_key;
        rec_t r_rec;

        if (i == 0)
        begin : g_first
            assign l_lt    = 1'b1;
            assign l_valid = 1'b0;
            assign l_key   = '0;
            assign l_rec   = '0;
        end
        else
        begin : g_mid_l
            assign l_lt    = lt_vec[i-1];
            assign l_valid = valid_vec[i-1];
            assign l_key   = key_arr[i-1];
            assign l_rec   = rec_arr[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_rec   = '0;
        end
        else
        begin : g_mid_r
            assign r_valid = valid_vec[i+1];
            assign r_key   = key_arr[i+1];
            assign r_rec   = rec_arr[i+1];
        end

        sar_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_lt     (l_lt),
            .left_valid  (l_valid),
            .left_key    (l_key),
            .left_rec    (l_rec),
            .right_valid (r_valid),
            .right_key   (r_key),
            .right_rec   (r_rec),
            .valid       (valid_vec[i]),
            .key         (key_arr[i]),
            .rec         (rec_arr[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i])
        );
    end

    // Locate the slot boundary and read out the matching record
    always_comb
    begin
        slot      = '0;
        found_rec = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (((i == 0) || lt_vec[(i == 0) ? 0 : i - 1]) && !lt_vec[i])
                slot = slot | PW'(i);
            if (eq_vec[i])
                found_rec = found_rec | rec_arr[i];
        end
        if (lt_vec[CAPACITY-1])
            slot = PW'(CAPACITY);
    end

    // Resolve status, position, reported record and new fill
    always_comb
    begin
        status_next = ST_OK;
        pos_next    = POS_W'(slot);
        rec_next    = '0;
        fill_next   = fill_reg;
        if (is_ins)
        begin
            if (full)
            begin
                status_next = ST_FULL;
                pos_next    = '0;
            end
            else if (hit)
            begin
                status_next = ST_DUPLICATE;
                rec_next    = found_rec;
            end
            else
            begin
                rec_next  = new_rec_reg;
                fill_next = fill_reg + PW'(1);
            end
        end
        else if (hit)
        begin
            rec_next = found_rec;
            if (is_del)
                fill_next = fill_reg - PW'(1);
        end
        else
        begin
            status_next = ST_NOT_FOUND;
        end
    end

    assign product = TOTAL_W'(res_rec_reg.elem_bytes) * TOTAL_W'(res_rec_reg.count);

    // Sequence one action and hold the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            act_reg        <= ACT_LOOKUP;
            key_reg        <= '0;
            new_rec_reg    <= '0;
            fill_reg       <= '0;
            res_status_reg <= ST_OK;
            res_pos_reg    <= '0;
            res_rec_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            m_beat_reg     <= '0;
            m_status_reg   <= ST_OK;
        end
        else
        begin
            // Drop a taken beat unless the emit step replaces it
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT))
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        act_reg     <= s_tuser;
                        key_reg     <= in_beat.key;
                        new_rec_reg <= in_beat.rec;
                        state_reg   <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_APPLY;
                end
                ST_APPLY:
                begin
                    res_status_reg <= status_next;
                    res_pos_reg    <= pos_next;
                    res_rec_reg    <= rec_next;
                    fill_reg       <= fill_next;
                    state_reg      <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_beat_reg.pad        <= '0;
                        m_beat_reg.occupancy  <= OCC_W'(fill_reg);
                        m_beat_reg.byte_total <= product;
                        m_beat_reg.rec        <= res_rec_reg;
                        m_beat_reg.position   <= res_pos_reg;
                        m_status_reg          <= res_status_reg;
                        m_tvalid_reg          <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_beat_reg;
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    // Keys in the chain are unique, so at most one cell matches
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(eq_vec))
        else $error("more than one cell matched the request key");

    // Lower-key flags form a prefix of the chain
    a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        (lt_vec & (lt_vec + CAPACITY'(1))) == '0)
        else $error("lower-key flags are not a prefix");

    // Occupied cells match the record count
    a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(fill_reg))
        else $error("occupied cells differ from fill count");

    // Fill never exceeds the table size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PW'(CAPACITY))
        else $error("fill count beyond capacity");

    // A full table never takes a new record
    a_full_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !ctl.ins_en)
        else $error("insert issued into a full table");
`endif

endmodule

`default_nettype wire

// ----- hdl/sar_cell.sv -----
// One slot of the sorted record chain: holds a key, a record and a valid bit.
// Depends on sar_pkg. Compares against the broadcast key and shifts with neighbors.
`default_nettype none

module sar_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire sar_pkg::cell_ctl_t ctl,
    input  wire logic              left_lt,
    input  wire logic              left_valid,
    input  wire sar_pkg::key_t     left_key,
    input  wire sar_pkg::rec_t     left_rec,
    input  wire logic              right_valid,
    input  wire sar_pkg::key_t     right_key,
    input  wire sar_pkg::rec_t     right_rec,
    output logic                   valid,
    output sar_pkg::key_t          key,
    output sar_pkg::rec_t          rec,
    output logic                   lt,
    output logic                   eq
);
    import sar_pkg::*;

    logic valid_reg;
    logic lt_reg;
    logic eq_reg;
    key_t key_reg;
    rec_t rec_reg;

    logic load_new;
    logic take_left;
    logic take_right;

    // Cells at or above the slot move; the first non-lower cell takes the new record
    assign load_new   = ctl.ins_en && !lt_reg && left_lt;
    assign take_left  = ctl.ins_en && !lt_reg && !left_lt;
    assign take_right = ctl.del_en && !lt_reg;

    // Hold occupancy and compare flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            if (ctl.cmp_en)
            begin
                lt_reg <= valid_reg && (key_reg < ctl.key);
                eq_reg <= valid_reg && (key_reg == ctl.key);
            end
            if (load_new)
                valid_reg <= 1'b1;
            else if (take_left)
                valid_reg <= left_valid;
            else if (take_right)
                valid_reg <= right_valid;
        end
    end

    // Move key and record along the chain
    always_ff @(posedge clk)
    begin
        if (load_new)
        begin
            key_reg <= ctl.key;
            rec_reg <= ctl.rec;
        end
        else if (take_left)
        begin
            key_reg <= left_key;
            rec_reg <= left_rec;
        end
        else if (take_right)
        begin
            key_reg <= right_key;
            rec_reg <= right_rec;
        end
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign rec   = rec_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire
